// File: sv/irfe_pkg.sv
// shared types, codes and timing constants of the ir remote frame encoder
`default_nettype none
package irfe_pkg;

    // protocol codes
    localparam logic [1:0] PROTO_NEC    = 2'd0;
    localparam logic [1:0] PROTO_NECEXT = 2'd1;
    localparam logic [1:0] PROTO_SAM32  = 2'd2;

    // timing in microseconds
    localparam logic [13:0] HDR_LONG_US   = 14'd9000;
    localparam logic [13:0] HDR_SHORT_US  = 14'd4500;
    localparam logic [12:0] HDR_SPACE_US  = 13'd4500;
    localparam logic [13:0] BIT_MARK_US   = 14'd560;
    localparam logic [12:0] ONE_SPACE_US  = 13'd1690;
    localparam logic [12:0] ZERO_SPACE_US = 13'd560;

    // frame layout: header, 32 bits, closing mark
    localparam int FRAME_BITS  = 32;
    localparam int FRAME_PAIRS = FRAME_BITS + 2;
    localparam int CNT_W       = $clog2(FRAME_PAIRS);
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(FRAME_PAIRS - 1);

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // input item
    typedef struct packed {
        logic [1:0]  protocol;
        logic [15:0] address;
        logic [7:0]  command;
    } irfe_in_t;

    // result item
    typedef struct packed {
        logic [13:0] mark_us;
        logic [12:0] space_us;
        logic        last;
        logic        rejected;
    } irfe_out_t;

    // classified item waiting for the back end
    typedef struct packed {
        logic [FRAME_BITS-1:0] word;
        logic                  long_hdr;
        logic                  rejected;
    } irfe_entry_t;

endpackage
`default_nettype wire

// File: sv/irfe_front.sv
// front end: accepts items, builds the frame word and header kind, and flags unknown protocols as rejected
`default_nettype none
module irfe_front (
    input  wire                   start,
    input  irfe_pkg::irfe_in_t    request,
    input  wire                   q_full,
    output logic                  busy,
    output logic                  push,
    output irfe_pkg::irfe_entry_t entry
);
    import irfe_pkg::*;

    logic [7:0] addr_lo;
    logic [7:0] second_byte;

    // accept while the queue has room
    assign busy = q_full;
    assign push = start && !q_full;
    assign addr_lo = request.address[7:0];

    // classify by protocol
    always_comb
    begin
        second_byte    = addr_lo;
        entry.long_hdr = 1'b1;
        entry.rejected = 1'b0;
        case (request.protocol)
            PROTO_NEC:
            begin
                second_byte = ~addr_lo;
            end
            PROTO_NECEXT:
            begin
                second_byte = request.address[15:8];
            end
            PROTO_SAM32:
            begin
                second_byte    = addr_lo;
                entry.long_hdr = 1'b0;
            end
            default:
            begin
                entry.rejected = 1'b1;
            end
        endcase
        entry.word = {~request.command, request.command, second_byte, addr_lo};
    end

endmodule
`default_nettype wire

// File: sv/irfe_queue.sv
// small register queue between front and back end
`default_nettype none
module irfe_queue #(
    parameter int DEPTH = irfe_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   push,
    input  irfe_pkg::irfe_entry_t wr_entry,
    input  wire                   pop,
    output irfe_pkg::irfe_entry_t rd_entry,
    output logic                  full,
    output logic                  not_empty
);
    import irfe_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W2 = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W2-1:0] CNT_FULL = CNT_W2'(DEPTH);

    irfe_entry_t       mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W2-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign rd_entry  = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_MAX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_MAX) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule
`default_nettype wire

// File: sv/irfe_back.sv
// back end: sequences header, bit and closing pairs, one item per cycle while a frame is active
`default_nettype none
module irfe_back (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   q_valid,
    input  irfe_pkg::irfe_entry_t q_entry,
    output logic                  pop,
    output logic                  strobe,
    output irfe_pkg::irfe_out_t   result
);
    import irfe_pkg::*;

    logic                  active_reg;
    logic [FRAME_BITS-1:0] word_reg;
    logic                  long_reg;
    logic                  rej_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  strobe_reg;
    irfe_out_t             pair_reg, pair_next;
    logic                  finishing;

    assign finishing = active_reg && (rej_reg || (cnt_reg == LAST_IDX));
    assign pop       = (!active_reg || finishing) && q_valid;
    assign strobe    = strobe_reg;
    assign result    = pair_reg;

    // pair for the current step
    always_comb
    begin
        pair_next.mark_us  = BIT_MARK_US;
        pair_next.space_us = word_reg[0] ? ONE_SPACE_US : ZERO_SPACE_US;
        pair_next.last     = 1'b0;
        pair_next.rejected = 1'b0;
        if (rej_reg)
        begin
            pair_next.mark_us  = '0;
            pair_next.space_us = '0;
            pair_next.last     = 1'b1;
            pair_next.rejected = 1'b1;
        end
        else if (cnt_reg == '0)
        begin
            pair_next.mark_us  = long_reg ? HDR_LONG_US : HDR_SHORT_US;
            pair_next.space_us = HDR_SPACE_US;
        end
        else if (cnt_reg == LAST_IDX)
        begin
            pair_next.space_us = '0;
            pair_next.last     = 1'b1;
        end
    end

    // sequencer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= active_reg;
            if (pop)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= '0;
            end
            else if (finishing)
            begin
                active_reg <= 1'b0;
            end
            else if (active_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // frame data, shifted out lsb first
    always_ff @(posedge clk)
    begin
        pair_reg <= pair_next;
        if (pop)
        begin
            word_reg <= q_entry.word;
            long_reg <= q_entry.long_hdr;
            rej_reg  <= q_entry.rejected;
        end
        else if (active_reg && (cnt_reg != '0))
        begin
            word_reg <= {1'b0, word_reg[FRAME_BITS-1:1]};
        end
    end

endmodule
`default_nettype wire

// File: sv/ir_remote_frame_encoder.sv
// top level: infrared frame encoder, front end, queue and pair sequencer
// an accepted item passes the queue, the sequencer registers and the pair register before its first pair shows
// throughput: one pair a cycle while a frame is active; a rejected item yields a single closing pair
// the pair sequencer sets the rate; the queue lets the next item wait meanwhile
// the receiver cannot stall: each pair shows for one cycle under strobe
// reset clears the queue pointers and the sequencer; no clearing pass
`default_nettype none
module ir_remote_frame_encoder #(
    parameter int QUEUE_DEPTH = irfe_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    input  irfe_pkg::irfe_in_t  request,
    output logic                busy,
    output logic                strobe,
    output irfe_pkg::irfe_out_t result
);
    import irfe_pkg::*;

    irfe_entry_t wr_entry;
    irfe_entry_t rd_entry;
    logic        push;
    logic        pop;
    logic        q_full;
    logic        q_valid;

    irfe_front u_front (
        .start   (start),
        .request (request),
        .q_full  (q_full),
        .busy    (busy),
        .push    (push),
        .entry   (wr_entry)
    );

    irfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_entry  (wr_entry),
        .pop       (pop),
        .rd_entry  (rd_entry),
        .full      (q_full),
        .not_empty (q_valid)
    );

    irfe_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_entry (rd_entry),
        .pop     (pop),
        .strobe  (strobe),
        .result  (result)
    );

    // a frame runs without gaps until its last pair
    a_frame_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last |=> strobe)
        else $error("gap inside a frame");

    // a rejected item is a single zero-duration closing item
    a_reject_shape: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.rejected |->
            result.last && (result.mark_us == '0) && (result.space_us == '0))
        else $error("malformed rejected item");

    // an item that is not last after a bit mark carries a bit space
    a_bit_space: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last && (result.mark_us == BIT_MARK_US) |->
            (result.space_us == ONE_SPACE_US) || (result.space_us == ZERO_SPACE_US))
        else $error("bad bit space");

    // the sequencer only pulls from a queue that holds an item
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("pop from empty queue");

endmodule
`default_nettype wire
